/* sv/bssr_pkg.sv */
// ----------------------------------------------------------------------------
// bssr_pkg
// Shared types and constants for the bounded stack with search and reverse.
// ----------------------------------------------------------------------------
package bssr_pkg;

    // Storage geometry
    localparam int DEPTH  = 256;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Field widths
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int POS_W  = 8;
    localparam int FILL_W = 9;
    localparam int LIM_W  = 9;

    // Compare width for count against the capacity register
    localparam int CMP_W = (CW > LIM_W) ? CW : LIM_W;

    // Packed stream widths
    localparam int IN_TDATA_W  = DATA_W;
    localparam int OUT_RAW_W   = DATA_W + POS_W + DATA_W + FILL_W + 1;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Capacity after reset
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(256);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [AW-1:0]     t_addr;
    typedef logic [CW-1:0]     t_count;

endpackage

/* sv/bounded_stack_with_search_reverse_unit.sv */
// ----------------------------------------------------------------------------
// bounded_stack_with_search_reverse_unit
// Bounded LIFO stack of 32-bit words with top-down search and in-place reverse.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream: tuser carries the kind (push, pop,
//   search, reverse), tdata the operand word. Each request yields one result
//   item on the master stream: tuser the status, tdata the popped word, match
//   position, top word, fill count and empty flag.
//   The words live in one 256-entry RAM with a registered read; all latency
//   comes from its single read port and single write port.
//   Path from accept to result in the output register:
//     push, refused push, empty pop, pop leaving zero entries, any request
//     that needs no walk: result loads at the accept edge
//     pop leaving entries: the new top is read back from the RAM first
//     search: walks down from the top until a match or the bottom entry
//     reverse: each pair is read low, read high, then written low, high
//   A new request is taken once the sequencer is idle and the output register
//   is empty or handing its item over in the same cycle; push runs one per
//   cycle while each result is taken. A stalled receiver holds the result and
//   holds off further requests until the item is taken; walks run to the end.
//   Reset empties the stack and sets the capacity to 256; RAM contents are
//   not cleared. The capacity register may be written only while idle.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_reverse_unit
    import bssr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration: capacity limit
    input  logic                   i_cfg_we,
    input  logic [LIM_W-1:0]       i_cfg_wdata,
    // Request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [31:0] operand_value
    input  logic [KIND_W-1:0]      i_s_axis_tuser,  // [1:0] kind
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] popped_value, [39:32] match_position, [71:40] top_value,
    // [80:72] fill_count, [81] is_empty, [87:82] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [STAT_W-1:0]      o_m_axis_tuser   // [1:0] status
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POP    = 3'd1;
    localparam logic [2:0] S_SRCH   = 3'd2;
    localparam logic [2:0] S_RV_RLO = 3'd3;
    localparam logic [2:0] S_RV_RHI = 3'd4;
    localparam logic [2:0] S_RV_WLO = 3'd5;
    localparam logic [2:0] S_RV_WHI = 3'd6;

    logic [2:0]        r_state, n_state;
    t_count            r_count, n_count;
    t_word             r_top, n_top;
    logic [LIM_W-1:0]  r_limit;
    t_word             r_key, n_key;
    t_addr             r_ptr, n_ptr;
    t_addr             r_cmp, n_cmp;
    logic              r_pend, n_pend;
    t_addr             r_lo, n_lo;
    t_addr             r_hi, n_hi;
    t_word             r_tmp, n_tmp;

    logic              r_ovalid, n_ovalid;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    t_word             r_o_pop, n_o_pop;
    logic [POS_W-1:0]  r_o_pos, n_o_pos;
    t_word             r_o_top, n_o_top;
    t_count            r_o_fill, n_o_fill;

    logic              ram_we;
    t_addr             ram_waddr;
    t_word             ram_wdata;
    t_addr             ram_raddr;
    t_word             ram_rdata;

    logic              s_acc;
    logic              full;
    logic [CMP_W-1:0]  lim_eff;
    logic [KIND_W-1:0] in_kind;
    t_word             in_val;

    assign in_kind = i_s_axis_tuser;
    assign in_val  = i_s_axis_tdata[DATA_W-1:0];

    bssr_ram #(
        .DW (DATA_W),
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take a request when idle and the result slot is free or draining
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Clamp the capacity to the storage depth
    assign lim_eff = (CMP_W'(r_limit) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(r_limit);
    assign full    = CMP_W'(r_count) >= lim_eff;

    // Sequencer: request decode, search walk, reverse swaps
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_top      = r_top;
        n_key      = r_key;
        n_ptr      = r_ptr;
        n_cmp      = r_cmp;
        n_pend     = r_pend;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_tmp      = r_tmp;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_o_status = r_o_status;
        n_o_pop    = r_o_pop;
        n_o_pos    = r_o_pos;
        n_o_top    = r_o_top;
        n_o_fill   = r_o_fill;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    // Defaults for an immediate result
                    n_o_status = ST_OK;
                    n_o_pop    = '0;
                    n_o_pos    = '0;
                    n_o_top    = (r_count == '0) ? '0 : r_top;
                    n_o_fill   = r_count;
                    n_ovalid   = 1'b1;
                    unique case (in_kind)
                        KIND_PUSH: begin
                            if (full) begin
                                n_o_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                ram_wdata = in_val;
                                n_count   = r_count + CW'(1);
                                n_top     = in_val;
                                n_o_top   = in_val;
                                n_o_fill  = r_count + CW'(1);
                            end
                        end
                        KIND_POP: begin
                            if (r_count == '0) begin
                                n_o_status = ST_EMPTY;
                            end else if (r_count == CW'(1)) begin
                                n_count  = '0;
                                n_o_pop  = r_top;
                                n_o_top  = '0;
                                n_o_fill = '0;
                            end else begin
                                // Fetch the word below the top
                                ram_raddr = AW'(r_count - CW'(2));
                                n_count   = r_count - CW'(1);
                                n_tmp     = r_top;
                                n_ovalid  = 1'b0;
                                n_state   = S_POP;
                            end
                        end
                        KIND_SEARCH: begin
                            if (r_count == '0) begin
                                n_o_status = ST_MISS;
                            end else begin
                                n_key    = in_val;
                                n_ptr    = AW'(r_count - CW'(1));
                                n_pend   = 1'b0;
                                n_ovalid = 1'b0;
                                n_state  = S_SRCH;
                            end
                        end
                        KIND_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                n_lo     = '0;
                                n_hi     = AW'(r_count - CW'(1));
                                n_ovalid = 1'b0;
                                n_state  = S_RV_RLO;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b0;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_top      = ram_rdata;
                n_o_status = ST_OK;
                n_o_pop    = r_tmp;
                n_o_pos    = '0;
                n_o_top    = ram_rdata;
                n_o_fill   = r_count;
                n_ovalid   = 1'b1;
                n_state    = S_IDLE;
            end
            S_SRCH: begin
                // Issue one read a cycle, compare the previous one
                ram_raddr = r_ptr;
                n_ptr     = r_ptr - AW'(1);
                n_cmp     = r_ptr;
                n_pend    = 1'b1;
                if (r_pend && ((ram_rdata == r_key) || (r_cmp == '0))) begin
                    n_o_status = (ram_rdata == r_key) ? ST_OK : ST_MISS;
                    n_o_pos    = (ram_rdata == r_key) ? POS_W'(r_cmp) : '0;
                    n_o_pop    = '0;
                    n_o_top    = r_top;
                    n_o_fill   = r_count;
                    n_ovalid   = 1'b1;
                    n_pend     = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_RV_RLO: begin
                ram_raddr = r_lo;
                n_state   = S_RV_RHI;
            end
            S_RV_RHI: begin
                ram_raddr = r_hi;
                n_tmp     = ram_rdata;
                n_state   = S_RV_WLO;
            end
            S_RV_WLO: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo;
                ram_wdata = ram_rdata;
                n_state   = S_RV_WHI;
            end
            S_RV_WHI: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                ram_wdata = r_tmp;
                // Old bottom becomes the new top
                if (r_lo == '0) begin
                    n_top = r_tmp;
                end
                n_lo = r_lo + AW'(1);
                n_hi = r_hi - AW'(1);
                if ({1'b0, r_hi} > ({1'b0, r_lo} + (AW + 1)'(2))) begin
                    n_state = S_RV_RLO;
                end else begin
                    n_o_status = ST_OK;
                    n_o_pop    = '0;
                    n_o_pos    = '0;
                    n_o_top    = n_top;
                    n_o_fill   = r_count;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_limit  <= LIM_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_key      <= n_key;
        r_ptr      <= n_ptr;
        r_cmp      <= n_cmp;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_tmp      <= n_tmp;
        r_o_status <= n_o_status;
        r_o_pop    <= n_o_pop;
        r_o_pos    <= n_o_pos;
        r_o_top    <= n_o_top;
        r_o_fill   <= n_o_fill;
    end

    // Pack the result item
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = OUT_TDATA_W'({(r_o_fill == '0), FILL_W'(r_o_fill),
                                          r_o_top, r_o_pos, r_o_pop});

    // Fill count stays within the storage depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("fill count beyond depth");

    // A push with room grows the stack by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_kind == KIND_PUSH) && !full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");

    // The result slot is empty while a walk is in progress
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ovalid)
        else $error("result pending during walk");

    // Reverse keeps the fill count
    a_rev_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RV_RLO) || (r_state == S_RV_RHI) || (r_state == S_RV_WLO)
         || (r_state == S_RV_WHI)) |=> $stable(r_count))
        else $error("reverse changed the fill count");

endmodule

/* sv/bssr_ram.sv */
// ----------------------------------------------------------------------------
// bssr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bssr_ram #(
    parameter int DW = 32,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
